// ===== src/kli_pkg.sv =====
// kli_pkg: shared constants for the keyframe interpolator
`timescale 1ns / 1ps

package kli_pkg;

    // input command codes
    localparam logic [1:0] CMD_WR_POS = 2'd0;
    localparam logic [1:0] CMD_WR_VAL = 2'd1;
    localparam logic [1:0] CMD_EVAL   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_KEY_COUNT  = 2'd1;
    localparam logic [1:0] CFG_PROP_COUNT = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    // blend fraction, 0..65536 inclusive
    localparam int FRAC_W = 17;
    localparam int DATA_W = 32;

endpackage

// ===== src/kli_div.sv =====
// kli_div: restoring divider for the blend fraction, one quotient bit per cycle
`timescale 1ns / 1ps

module kli_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [kli_pkg::DATA_W-1:0]  i_num,
    input  logic [kli_pkg::DATA_W-1:0]  i_den,
    output logic                        o_done,
    output logic [kli_pkg::FRAC_W-1:0]  o_quot
);
    import kli_pkg::*;

    localparam int CW = $clog2(FRAC_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_den;
    logic [FRAC_W-1:0] r_quot;
    logic              r_den_zero;

    logic              w_ge;
    logic [DATA_W:0]   w_rem_sub;

    // num never exceeds den, so the first step yields the integer bit
    assign w_ge      = r_rem >= {1'b0, r_den};
    assign w_rem_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy     <= 1'b1;
                r_cnt      <= CW'(FRAC_W - 1);
                r_rem      <= {1'b0, i_num};
                r_den      <= i_den;
                r_den_zero <= (i_den == '0);
            end else if (r_busy) begin
                r_quot <= {r_quot[FRAC_W-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    r_rem <= {w_rem_sub[DATA_W-1:0], 1'b0};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_den_zero ? '0 : r_quot;

endmodule

// ===== src/keyframe_linear_interpolator_core.sv =====
// keyframe_linear_interpolator_core: keyframe table with linear blend evaluation
`timescale 1ns / 1ps
//
// Input channel i_in_valid / o_in_stall carries commands: write a key position,
// write one property value of a key, or evaluate at a position. An evaluate
// scans the keys in slot order through states S_SRD and S_SCMP, using
// the position memory read port, stops at the first key at or above the
// position once a key below it was seen, runs a serial divide for the
// blend fraction when the position lies between two keys, then produces one
// result per property through two value memory reads, one multiply and one
// add. o_in_stall stays high until the last result of an evaluate is in the
// output register.
// Results leave on o_out_valid / i_out_stall through a single output register;
// a stalled receiver holds the result and pauses the sequencer, and no result
// is lost. The next command is taken while the final result still waits.
// Reset clears the sequencer and output valid and sets enabled=1, key_count=0,
// prop_count=0. Table contents are not cleared; read only what was written.
// Write configuration through i_cfg_we only while idle; the core does not check.

module keyframe_linear_interpolator_core #(
    parameter int MAX_KEYS  = 16,
    parameter int MAX_PROPS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [kli_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [kli_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_cmd,
    input  logic [3:0]                        i_key_index,
    input  logic [2:0]                        i_prop_index,
    input  logic [31:0]                       i_position,
    input  logic signed [31:0]                i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [2:0]                        o_prop_slot,
    output logic signed [31:0]                o_prop_value,
    output logic                              o_last
);
    import kli_pkg::*;

    localparam int KW  = $clog2(MAX_KEYS);
    localparam int PW  = (MAX_PROPS > 1) ? $clog2(MAX_PROPS) : 1;
    localparam int VD  = MAX_KEYS * MAX_PROPS;
    localparam int AW  = $clog2(VD);
    localparam int NKW = $clog2(MAX_KEYS + 1);
    localparam int NPW = $clog2(MAX_PROPS + 1);
    localparam int PRW = DATA_W + 1 + FRAC_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_DIV,
        S_DWAIT,
        S_RDL,
        S_RDR,
        S_MUL,
        S_OUT
    } t_state;

    // configuration
    logic           r_enabled;
    logic [4:0]     r_key_count;
    logic [3:0]     r_prop_count;

    // tables
    logic [DATA_W-1:0] r_kmem [MAX_KEYS];
    logic [DATA_W-1:0] r_vmem [VD];
    logic [DATA_W-1:0] r_kq;
    logic [DATA_W-1:0] r_vq;

    // sequencer
    t_state            r_state;
    t_state            n_state;
    logic [DATA_W-1:0] r_pos;
    logic [NKW-1:0]    r_nk;
    logic [NPW-1:0]    r_np;
    logic [KW-1:0]     r_idx;
    logic              r_prev_gt;
    logic [KW-1:0]     r_left;
    logic [KW-1:0]     r_right;
    logic [DATA_W-1:0] r_lpos;
    logic [DATA_W-1:0] r_rpos;
    logic [FRAC_W-1:0] r_frac;
    logic [PW-1:0]     r_prop;
    logic [DATA_W-1:0] r_vl;
    logic signed [PRW-1:0] r_prod;

    logic              r_out_valid;
    logic [2:0]        r_out_slot;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_last;

    logic              w_accept;
    logic [NKW-1:0]    w_nk_eff;
    logic [NPW-1:0]    w_np_eff;
    logic              w_key_ok;
    logic              w_prop_ok;
    logic              w_kwe;
    logic              w_vwe;
    logic [KW-1:0]     w_kwaddr;
    logic [AW-1:0]     w_vwaddr;
    logic [AW-1:0]     w_vraddr;
    logic              w_gt;
    logic              w_brk;
    logic              w_last_key;
    logic              w_last_prop;
    logic              w_out_free;
    logic              w_div_done;
    logic [FRAC_W-1:0] w_quot;
    logic signed [DATA_W:0]   w_diff;
    logic signed [FRAC_W:0]   w_fs;
    logic signed [PRW-1:0]    w_prod;
    logic [DATA_W-1:0] w_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    assign w_nk_eff = (32'(r_key_count) > 32'(MAX_KEYS)) ? NKW'(MAX_KEYS) : NKW'(r_key_count);
    assign w_np_eff = (32'(r_prop_count) > 32'(MAX_PROPS)) ? NPW'(MAX_PROPS)
                                                           : NPW'(r_prop_count);

    assign w_key_ok  = 32'(i_key_index) < 32'(MAX_KEYS);
    assign w_prop_ok = 32'(i_prop_index) < 32'(MAX_PROPS);
    assign w_kwe     = w_accept && (i_cmd == CMD_WR_POS) && w_key_ok;
    assign w_vwe     = w_accept && (i_cmd == CMD_WR_VAL) && w_key_ok && w_prop_ok;
    assign w_kwaddr  = KW'(i_key_index);
    assign w_vwaddr  = AW'(32'(i_key_index) * 32'(MAX_PROPS) + 32'(i_prop_index));
    assign w_vraddr  = (r_state == S_RDR)
                     ? AW'(32'(r_right) * 32'(MAX_PROPS) + 32'(r_prop))
                     : AW'(32'(r_left) * 32'(MAX_PROPS) + 32'(r_prop));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= 1'b1;
            r_key_count  <= '0;
            r_prop_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLED:    r_enabled    <= i_cfg_wdata[0];
                CFG_KEY_COUNT:  r_key_count  <= i_cfg_wdata[4:0];
                CFG_PROP_COUNT: r_prop_count <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // key position memory, read address follows the scan index
    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            r_kmem[w_kwaddr] <= i_position;
        end
        r_kq <= r_kmem[r_idx];
    end

    // property value memory
    always_ff @(posedge i_clk) begin
        if (w_vwe) begin
            r_vmem[w_vwaddr] <= i_value;
        end
        r_vq <= r_vmem[w_vraddr];
    end

    kli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV),
        .i_num   (r_pos - r_lpos),
        .i_den   (r_rpos - r_lpos),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // scan: a key at or above the position right after one below it ends the search
    assign w_gt        = r_pos > r_kq;
    assign w_brk       = r_prev_gt && !w_gt;
    assign w_last_key  = (32'(r_idx) + 32'd1) == 32'(r_nk);
    assign w_last_prop = (32'(r_prop) + 32'd1) == 32'(r_np);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // vl + floor((vr - vl) * f / 65536) equals the blend of both keys
    assign w_diff = $signed({r_vq[DATA_W-1], r_vq}) - $signed({r_vl[DATA_W-1], r_vl});
    assign w_fs   = $signed({1'b0, r_frac});
    assign w_prod = w_diff * w_fs;
    assign w_res  = r_vl + r_prod[DATA_W+FRAC_W-2:FRAC_W-1];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_cmd == CMD_EVAL) && r_enabled
                    && (w_nk_eff != '0) && (w_np_eff != '0)) begin
                    n_state = S_SRD;
                end
            end
            S_SRD:   n_state = S_SCMP;
            S_SCMP: begin
                if (w_brk) begin
                    n_state = S_DIV;
                end else if (w_last_key) begin
                    n_state = S_RDL;
                end else begin
                    n_state = S_SRD;
                end
            end
            S_DIV:   n_state = S_DWAIT;
            S_DWAIT: n_state = w_div_done ? S_RDL : S_DWAIT;
            S_RDL:   n_state = S_RDR;
            S_RDR:   n_state = S_MUL;
            S_MUL:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = w_last_prop ? S_IDLE : S_RDL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_pos     <= i_position;
                    r_nk      <= w_nk_eff;
                    r_np      <= w_np_eff;
                    r_idx     <= '0;
                    r_prev_gt <= 1'b0;
                    r_left    <= '0;
                    r_prop    <= '0;
                end
                S_SCMP: begin
                    if (w_brk) begin
                        r_right <= r_idx;
                        r_rpos  <= r_kq;
                    end else begin
                        r_prev_gt <= w_gt;
                        if (w_gt) begin
                            r_left <= r_idx;
                            r_lpos <= r_kq;
                        end
                        if (w_last_key) begin
                            // held value: both reads hit the same key, fraction zero
                            r_frac  <= '0;
                            r_right <= w_gt ? r_idx : r_left;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        r_frac <= w_quot;
                    end
                end
                S_RDR: begin
                    r_vl <= r_vq;
                end
                S_MUL: begin
                    r_prod <= w_prod;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_slot  <= 3'(r_prop);
                        r_out_value <= w_res;
                        r_out_last  <= w_last_prop;
                        r_prop      <= r_prop + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_prop_slot  = r_out_slot;
    assign o_prop_value = r_out_value;
    assign o_last       = r_out_last;

endmodule
